/* sv/skse_pkg.sv */
// Shared operation codes, status codes and cell command type for the sorted key set.
package skse_pkg;

    // Request operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_SUCC   = 3'd3;
    localparam logic [2:0] OP_FIRST  = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    // Broadcast command to every cell in the chain
    typedef struct packed {
        logic cmp;   // latch compare flags against the request key
        logic ins;   // open a slot at the insert point and shift up
        logic rem;   // close the slot at the match and shift down
    } t_cell_cmd;

endpackage

/* sv/skse_cell.sv */
// One slot of the sorted key chain: holds a key and its compare flags.
module skse_cell #(
    parameter int KW = 32
) (
    input  logic                 i_clk,
    input  skse_pkg::t_cell_cmd  i_cmd,
    input  logic [KW-1:0]        i_req_key,
    input  logic                 i_occ,
    input  logic                 i_lt_prev,
    input  logic [KW-1:0]        i_prev_key,
    input  logic [KW-1:0]        i_next_key,
    output logic [KW-1:0]        o_key,
    output logic                 o_lt,
    output logic                 o_eq,
    output logic                 o_gt
);

    logic [KW-1:0] r_key;
    logic          r_lt;
    logic          r_eq;
    logic          r_gt;

    // Latch the compare flags; an empty slot reports none of them
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_lt <= i_occ && (r_key <  i_req_key);
            r_eq <= i_occ && (r_key == i_req_key);
            r_gt <= i_occ && (r_key >  i_req_key);
        end
    end

    // Shift keys at and above the insert or remove point
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !r_lt) begin
            r_key <= i_lt_prev ? i_req_key : i_prev_key;
        end else if (i_cmd.rem && !r_lt) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_gt  = r_gt;

endmodule

/* sv/sorted_key_set_engine.sv */
// Sorted key set: a chain of key cells with a request sequencer and result register.
// Each request passes a compare step, then an update step that registers the result.
// A new request is taken only in the idle phase, after the last one's compare-then-shift pass over the cell chain.
// A result that waits on the output does not block the next input beat; that request then
// holds in its update step until the output register frees.
// Reset (synchronous, active low) empties the set and drops any pending result.
module sorted_key_set_engine #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [31:0] o_value,
    output logic [6:0]  o_count,
    output logic [1:0]  o_status
);

    localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMP  = 2'd1;
    localparam logic [1:0] PH_RES  = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [2:0]    r_op;
    logic [KW-1:0] r_key;
    logic [CW-1:0] r_count, n_count;

    logic          r_ovalid;
    logic          r_found, n_found;
    logic [KW-1:0] r_value, n_value;
    logic [1:0]    r_status, n_status;

    skse_pkg::t_cell_cmd cmd;
    logic [KW-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] lt, eq, gt, occ, sel;
    logic [KW-1:0] succ_key;
    logic          fire;
    logic          hit;
    logic          do_ins, do_rem;

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic          lt_prev;
        logic [KW-1:0] prev_key;
        logic [KW-1:0] next_key;

        if (g == 0) begin : g_head
            assign lt_prev  = 1'b1;
            assign prev_key = r_key;
            assign sel[g]   = gt[g];
        end else begin : g_body
            assign lt_prev  = lt[g-1];
            assign prev_key = cell_key[g-1];
            assign sel[g]   = gt[g] && !gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_key = cell_key[g];
        end else begin : g_mid
            assign next_key = cell_key[g+1];
        end

        assign occ[g] = (r_count > CW'(g));

        skse_cell #(.KW(KW)) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_req_key  (r_key),
            .i_occ      (occ[g]),
            .i_lt_prev  (lt_prev),
            .i_prev_key (prev_key),
            .i_next_key (next_key),
            .o_key      (cell_key[g]),
            .o_lt       (lt[g]),
            .o_eq       (eq[g]),
            .o_gt       (gt[g])
        );
    end

    // Pick the successor key: the first cell above the request key
    always_comb begin
        succ_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            succ_key = succ_key | (sel[i] ? cell_key[i] : '0);
        end
    end

    assign hit  = |eq;
    assign fire = (r_phase == PH_RES) && (!r_ovalid || i_ready);

    // Decide the result and the chain update
    always_comb begin
        n_found  = 1'b0;
        n_value  = '0;
        n_status = skse_pkg::ST_OK;
        n_count  = r_count;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        case (r_op)
            skse_pkg::OP_INSERT: begin
                if (r_key == '0) begin
                    n_status = skse_pkg::ST_NONE;
                end else if (hit) begin
                    n_found = 1'b1;
                    n_value = r_key;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_status = skse_pkg::ST_FULL;
                end else begin
                    n_value = r_key;
                    n_count = r_count + CW'(1);
                    do_ins  = 1'b1;
                end
            end
            skse_pkg::OP_REMOVE: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_value = r_key;
                    n_count = r_count - CW'(1);
                    do_rem  = 1'b1;
                end else begin
                    n_status = skse_pkg::ST_NONE;
                end
            end
            skse_pkg::OP_LOOKUP: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_value = r_key;
                end else begin
                    n_status = skse_pkg::ST_NONE;
                end
            end
            skse_pkg::OP_SUCC: begin
                if (|sel) begin
                    n_found = 1'b1;
                    n_value = succ_key;
                end else begin
                    n_status = skse_pkg::ST_NONE;
                end
            end
            skse_pkg::OP_FIRST: begin
                if (r_count != '0) begin
                    n_found = 1'b1;
                    n_value = cell_key[0];
                end else begin
                    n_status = skse_pkg::ST_NONE;
                end
            end
            skse_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign cmd.cmp = (r_phase == PH_CMP);
    assign cmd.ins = fire && do_ins;
    assign cmd.rem = fire && do_rem;

    // Advance the request sequencer
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: if (i_valid) n_phase = PH_CMP;
            PH_CMP:  n_phase = PH_RES;
            PH_RES:  if (fire) n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (fire) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op  <= i_op;
            r_key <= i_key[KW-1:0];
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_found  <= n_found;
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_ready  = (r_phase == PH_IDLE);
    assign o_valid  = r_ovalid;
    assign o_found  = r_found;
    assign o_value  = 32'(r_value);
    assign o_count  = 7'(r_count);
    assign o_status = r_status;

endmodule

/* sv/skse_check.sv */
// Port-level checks for the sorted key set, bound to the top level.
module skse_check #(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [31:0] o_value,
    input logic [6:0]  o_count,
    input logic [1:0]  o_status
);

    // Count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_count) <= CAPACITY))
        else $error("result count above capacity");

    // A refused insert returns nothing
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == skse_pkg::ST_FULL) |-> (!o_found && o_value == 32'd0))
        else $error("refused insert carries a key");

    // A found result carries a nonzero key and ok status
    a_found_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_value != 32'd0 && o_status == skse_pkg::ST_OK))
        else $error("found result without key or with error status");

    // A request beat is followed by the busy window
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after a request beat");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_value) && $stable(o_count)))
        else $error("stalled result changed");

endmodule

bind sorted_key_set_engine skse_check #(.CAPACITY(CAPACITY)) u_skse_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_found  (o_found),
    .o_value  (o_value),
    .o_count  (o_count),
    .o_status (o_status)
);

/* test/skse_checker.sv */
// Checker for the sorted key set: watches both channels, predicts each result and compares.
module skse_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_key,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_found,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_count,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_refused
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        found;
        logic [31:0] value;
        logic [6:0]  count;
        logic [1:0]  status;
    } t_set_answer;

    // Shadow copy of the set, ascending in slots below set_size
    logic [31:0] set_keys [CAPACITY];
    int          set_size = 0;

    t_set_answer awaited_answers[$];
    int          mismatches   = 0;
    int          answers_seen = 0;
    int          full_refusals = 0;

    // Apply one request to the shadow set and return the answer it should give
    function automatic t_set_answer apply_set_request(logic [2:0] op, logic [31:0] key);
        t_set_answer ans;
        int          pos;
        logic        hit;
        ans = '0;
        pos = 0;
        while (pos < set_size && set_keys[pos] < key)
            pos++;
        hit = (pos < set_size) && (set_keys[pos] == key);
        case (op)
            skse_pkg::OP_INSERT: begin
                if (key == '0) begin
                    ans.status = skse_pkg::ST_NONE;
                end else if (hit) begin
                    ans.found = 1'b1;
                    ans.value = key;
                end else if (set_size >= CAPACITY) begin
                    ans.status = skse_pkg::ST_FULL;
                end else begin
                    // open a slot at the insert point
                    for (int i = set_size; i > pos; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[pos] = key;
                    set_size++;
                    ans.value = key;
                end
            end
            skse_pkg::OP_REMOVE: begin
                if (key != '0 && hit) begin
                    // close the slot over the match
                    for (int i = pos; i < set_size - 1; i++)
                        set_keys[i] = set_keys[i+1];
                    set_size--;
                    ans.found = 1'b1;
                    ans.value = key;
                end else begin
                    ans.status = skse_pkg::ST_NONE;
                end
            end
            skse_pkg::OP_LOOKUP: begin
                if (key != '0 && hit) begin
                    ans.found = 1'b1;
                    ans.value = key;
                end else begin
                    ans.status = skse_pkg::ST_NONE;
                end
            end
            skse_pkg::OP_SUCC: begin
                // skip an exact match: successor is strictly greater
                if (hit)
                    pos++;
                if (pos < set_size) begin
                    ans.found = 1'b1;
                    ans.value = set_keys[pos];
                end else begin
                    ans.status = skse_pkg::ST_NONE;
                end
            end
            skse_pkg::OP_FIRST: begin
                if (set_size > 0) begin
                    ans.found = 1'b1;
                    ans.value = set_keys[0];
                end else begin
                    ans.status = skse_pkg::ST_NONE;
                end
            end
            skse_pkg::OP_CLEAR: begin
                set_size   = 0;
                ans.status = skse_pkg::ST_OK;
            end
            default: ;
        endcase
        ans.count = 7'(set_size);
        return ans;
    endfunction

    task automatic flag_mismatch(string why, t_set_answer want, t_set_answer got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t mismatch (%s): expected found=%0b value=%08h count=%0d status=%0d,",
                     $realtime, why, want.found, want.value, want.count, want.status,
                     " got found=%0b value=%08h count=%0d status=%0d",
                     got.found, got.value, got.count, got.status);
    endtask

    // Check result beats first, then record request beats of the same edge
    always @(posedge i_clk) begin
        t_set_answer want;
        t_set_answer got;
        if (!i_rst_n) begin
            set_size = 0;
            awaited_answers.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = {i_found, i_value, i_count, i_status};
                answers_seen++;
                if (awaited_answers.size() == 0) begin
                    flag_mismatch("result with no request outstanding", '0, got);
                end else begin
                    want = awaited_answers.pop_front();
                    if (want !== got)
                        flag_mismatch("field differs", want, got);
                end
            end
            if (i_req_valid && i_req_ready) begin
                want = apply_set_request(i_op, i_key);
                if (want.status == skse_pkg::ST_FULL)
                    full_refusals++;
                awaited_answers.push_back(want);
            end
        end
        o_errors  <= mismatches;
        o_pending <= awaited_answers.size();
        o_results <= answers_seen;
        o_refused <= full_refusals;
    end

endmodule

/* test/tb_sorted_key_set_engine.sv */
// Testbench top for the sorted key set: drives requests and result stalls, gives the verdict.
module tb_sorted_key_set_engine;

    localparam int CAPACITY        = 64;
    localparam int KEY_POOL_SIZE   = 96;
    localparam int FILL_INSERTS    = 70;
    localparam int MIXED_PER_PHASE = 150;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int RESET_CYCLES    = 6;

    // Op codes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} t_op_mix;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [2:0]  i_op    = skse_pkg::OP_INSERT;
    logic [31:0] i_key   = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_found;
    logic [31:0] o_value;
    logic [6:0]  o_count;
    logic [1:0]  o_status;

    int          check_errors;
    int          results_pending;
    int          results_checked;
    int          refused_inserts;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          requests_sent  = 0;
    int          quiet_cycles   = 0;
    logic [31:0] key_pool [KEY_POOL_SIZE];

    always #5 i_clk = ~i_clk;

    sorted_key_set_engine #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (32)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .i_key    (i_key),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_found  (o_found),
        .o_value  (o_value),
        .o_count  (o_count),
        .o_status (o_status)
    );

    skse_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_ready (o_ready),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_res_valid (o_valid),
        .i_res_ready (i_ready),
        .i_found     (o_found),
        .i_value     (o_value),
        .i_count     (o_count),
        .i_status    (o_status),
        .o_errors    (check_errors),
        .o_pending   (results_pending),
        .o_results   (results_checked),
        .o_refused   (refused_inserts)
    );

    // Stall the result channel at the current rate
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    // End the run when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, results_pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one request beat, idling first at the current rate, and hold it until taken
    task automatic send_request(logic [2:0] op, logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        do
            @(posedge i_clk);
        while (!o_ready);
        requests_sent++;
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
    endtask

    // Mostly keys from the pool so that hits happen, some zero, some fresh or off by one
    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 15)
            return $urandom;
        else if (roll < 22)
            return key_pool[$urandom_range(KEY_POOL_SIZE - 1)] + 32'd1;
        else
            return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    endfunction

    function automatic logic [2:0] pick_op(t_op_mix mix);
        int roll;
        int ins_cut;
        int rem_cut;
        roll = $urandom_range(99);
        if (roll < 1)
            return skse_pkg::OP_CLEAR;
        if (roll < 2)
            return $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
        case (mix)
            MIX_FILL:  begin ins_cut = 62; rem_cut = 70; end
            MIX_DRAIN: begin ins_cut = 12; rem_cut = 57; end
            default:   begin ins_cut = 30; rem_cut = 50; end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_cut)
            return skse_pkg::OP_INSERT;
        else if (roll < rem_cut)
            return skse_pkg::OP_REMOVE;
        else if (roll < rem_cut + (100 - rem_cut) / 3)
            return skse_pkg::OP_LOOKUP;
        else if (roll < 90)
            return skse_pkg::OP_SUCC;
        else
            return skse_pkg::OP_FIRST;
    endfunction

    initial begin
        int      fill_start;
        int      mix_left;
        t_op_mix mix;

        // Build the key pool: extremes, a tight run for successor, then wide random keys
        key_pool[0] = 32'h0000_0001;
        key_pool[1] = 32'h0000_0002;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'hFFFF_FFFE;
        key_pool[4] = 32'h8000_0000;
        key_pool[5] = 32'h7FFF_FFFF;
        for (int i = 6; i < 38; i++)
            key_pool[i] = 32'h0000_1000 + 32'(i);
        for (int i = 38; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            if (key_pool[i] == '0)
                key_pool[i] = 32'h0000_0003;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty set, zero key, extremes, duplicates, misses, unused ops, clear
        send_request(skse_pkg::OP_FIRST,  32'h0000_0000);
        send_request(skse_pkg::OP_SUCC,   32'h0000_0000);
        send_request(skse_pkg::OP_INSERT, 32'h0000_0000);
        send_request(skse_pkg::OP_LOOKUP, 32'h0000_0000);
        send_request(skse_pkg::OP_REMOVE, 32'h0000_0000);
        send_request(skse_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_request(skse_pkg::OP_INSERT, 32'h0000_0001);
        send_request(skse_pkg::OP_INSERT, 32'h0000_0001);
        send_request(skse_pkg::OP_INSERT, 32'h8000_0000);
        send_request(skse_pkg::OP_LOOKUP, 32'h0000_0001);
        send_request(skse_pkg::OP_LOOKUP, 32'h0000_0005);
        send_request(skse_pkg::OP_SUCC,   32'h0000_0000);
        send_request(skse_pkg::OP_SUCC,   32'h0000_0001);
        send_request(skse_pkg::OP_SUCC,   32'h4000_0000);
        send_request(skse_pkg::OP_SUCC,   32'hFFFF_FFFF);
        send_request(skse_pkg::OP_REMOVE, 32'h0000_0005);
        send_request(skse_pkg::OP_REMOVE, 32'h0000_0001);
        send_request(skse_pkg::OP_FIRST,  32'h0000_0000);
        send_request(OP_SPARE_A, 32'hFFFF_FFFF);
        send_request(OP_SPARE_B, 32'h0000_0000);
        send_request(skse_pkg::OP_CLEAR,  32'hFFFF_FFFF);
        send_request(skse_pkg::OP_FIRST,  32'h0000_0000);
        send_request(skse_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
        wait_for_drain();

        // Four pacing phases: free flow, idle sender, stalled receiver, both lightly
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase

            // Fill from empty past capacity, then retry a stored key at full
            send_request(skse_pkg::OP_CLEAR, $urandom);
            fill_start = $urandom_range(KEY_POOL_SIZE - 1);
            for (int i = 0; i < FILL_INSERTS; i++)
                send_request(skse_pkg::OP_INSERT,
                             key_pool[(fill_start + i) % KEY_POOL_SIZE]);
            send_request(skse_pkg::OP_INSERT, key_pool[fill_start]);

            // Mixed traffic in stretches that lean toward filling, churning or draining
            mix_left = 0;
            mix      = MIX_CHURN;
            for (int i = 0; i < MIXED_PER_PHASE; i++) begin
                if (mix_left == 0) begin
                    mix_left = $urandom_range(20, 60);
                    mix      = t_op_mix'($urandom_range(2));
                end
                mix_left--;
                send_request(pick_op(mix), pick_key());
            end
            wait_for_drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d checked results over four pacing phases,",
                 requests_sent, results_checked);
        $display("including %0d inserts refused at full capacity.", refused_inserts);
        if (check_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
